### hdl/taylor_sine_cosine_tangent_assert.svh
// assertion macros shared by the sine cosine tangent unit
`ifndef TAYLOR_SINE_COSINE_TANGENT_ASSERT_SVH
`define TAYLOR_SINE_COSINE_TANGENT_ASSERT_SVH
`ifndef SYNTH
`define TSCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TSCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TSCT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSCT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/tsct_pkg.sv
`timescale 1ns / 1ps
package tsct_pkg;

   // series length and fixed-point layout
   localparam int SERIES_TERMS = 10;
   localparam int NT   = SERIES_TERMS - 1;
   localparam int FRAC = 28;
   localparam int XW   = 32;
   localparam int SQW  = 35;
   localparam int QW   = 34;
   localparam int QHW  = 17;
   localparam int TW   = 41;
   localparam int MW   = 40;
   localparam int SUMW = 44;
   localparam int OUTW = 48;
   localparam int QOW  = 48;
   localparam int NUMW = MW + FRAC;
   localparam int DIVW = 10;
   localparam int RW   = 46;
   localparam int RHW  = 23;
   localparam int RSH  = 46;

   localparam logic signed [OUTW-1:0] OUT_MAX = {1'b0, {(OUTW-1){1'b1}}};
   localparam logic signed [OUTW-1:0] OUT_MIN = {1'b1, {(OUTW-1){1'b0}}};
   localparam logic [QOW-1:0] QUO_MID = {1'b1, {(QOW-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_SINE    = 2'd0,
      OP_COSINE  = 2'd1,
      OP_TANGENT = 2'd2
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } ctrl_type;

   typedef logic [NT-1:0][QW-1:0] qvec_type;

   // angle and its square as they leave the first stage
   typedef struct packed {
      ctrl_type                ctrl;
      logic signed [XW-1:0]    x;
      logic [SQW-1:0]          sq;
   } qhead_type;

   // one step of the restoring divider
   typedef struct packed {
      ctrl_type                ctrl;
      logic [MW-1:0]           rem;
      logic [MW-1:0]           num;
      logic [MW-1:0]           den;
      logic [QOW-1:0]          quo;
      logic                    big;
      logic                    neg;
      logic                    zero;
      logic signed [SUMW-1:0]  pass;
   } div_type;

   // term divisor 2i(2i+1) for sine, 2i(2i-1) for cosine
   function automatic logic [DIVW-1:0] divisor(int i, int kind);
      int d;
      d = (kind != 0) ? (2 * i) * (2 * i - 1) : (2 * i) * (2 * i + 1);
      return DIVW'(d);
   endfunction

   function automatic logic [MW-1:0] term_mag(logic signed [TW-1:0] v);
      logic [TW-1:0] u;
      u = v;
      if (v[TW-1]) u = ~u + 1'b1;
      return u[MW-1:0];
   endfunction

   function automatic logic [MW-1:0] sum_mag(logic signed [SUMW-1:0] v);
      logic [SUMW-1:0] u;
      u = v;
      if (v[SUMW-1]) u = ~u + 1'b1;
      return u[MW-1:0];
   endfunction

endpackage

### hdl/tsct_quot.sv
`timescale 1ns / 1ps
module tsct_quot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  tsct_pkg::qhead_type  in_head,
   output tsct_pkg::qhead_type  out_head,
   output tsct_pkg::qvec_type   out_qs,
   output tsct_pkg::qvec_type   out_qc
);

   localparam int PLW   = tsct_pkg::SQW + tsct_pkg::RHW;
   localparam int FULLW = tsct_pkg::SQW + tsct_pkg::RW;
   localparam int PRW   = tsct_pkg::QW + tsct_pkg::DIVW;

   tsct_pkg::qhead_type head1_ff, head2_ff, head3_ff;
   wire [tsct_pkg::QW-1:0] q_all [2][tsct_pkg::NT];

   // angle and square travel alongside the quotient units
   always_ff @(posedge clock) begin
      if (reset) begin
         head1_ff.ctrl.valid <= 1'b0;
         head2_ff.ctrl.valid <= 1'b0;
         head3_ff.ctrl.valid <= 1'b0;
      end else if (adv) begin
         head1_ff <= in_head;
         head2_ff <= head1_ff;
         head3_ff <= head2_ff;
      end
   end

   // floor(sq / d) by reciprocal multiply and one correction step
   for (genvar gc = 0; gc < 2; gc++) begin : g_kind
      for (genvar gj = 0; gj < tsct_pkg::NT; gj++) begin : g_term
         localparam logic [tsct_pkg::DIVW-1:0] D = tsct_pkg::divisor(gj + 1, gc);
         localparam logic [63:0] RFULL = (64'd1 << tsct_pkg::RSH) / 64'(D);
         localparam logic [tsct_pkg::RW-1:0] R = RFULL[tsct_pkg::RW-1:0];

         logic [PLW-1:0]          pl_in, ph_in, pl_ff, ph_ff;
         logic [FULLW-1:0]        full;
         logic [tsct_pkg::QW-1:0] qe_in, qe_ff, q_in, q_ff;
         logic [PRW-1:0]          prod, rdiff;

         always_comb begin
            pl_in = PLW'(in_head.sq) * PLW'(R[tsct_pkg::RHW-1:0]);
            ph_in = PLW'(in_head.sq) * PLW'(R[tsct_pkg::RW-1:tsct_pkg::RHW]);
            full  = FULLW'(pl_ff) + (FULLW'(ph_ff) << tsct_pkg::RHW);
            qe_in = full[tsct_pkg::RSH +: tsct_pkg::QW];
            prod  = PRW'(qe_ff) * PRW'(D);
            rdiff = PRW'(head2_ff.sq) - prod;
            q_in  = (rdiff >= PRW'(D)) ? qe_ff + 1'b1 : qe_ff;
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               pl_ff <= pl_in;
               ph_ff <= ph_in;
               qe_ff <= qe_in;
               q_ff  <= q_in;
            end
         end

         assign q_all[gc][gj] = q_ff;
      end
   end

   // gather the quotient vectors
   always_comb begin
      for (int j = 0; j < tsct_pkg::NT; j++) begin
         out_qs[j] = q_all[0][j];
         out_qc[j] = q_all[1][j];
      end
   end

   assign out_head = head3_ff;

endmodule

### hdl/tsct_series.sv
`timescale 1ns / 1ps
module tsct_series (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  tsct_pkg::qhead_type             in_head,
   input  tsct_pkg::qvec_type              in_qs,
   input  tsct_pkg::qvec_type              in_qc,
   output tsct_pkg::ctrl_type              out_ctrl,
   output logic signed [tsct_pkg::SUMW-1:0] out_sin,
   output logic signed [tsct_pkg::SUMW-1:0] out_cos
);

   localparam int TW   = tsct_pkg::TW;
   localparam int SUMW = tsct_pkg::SUMW;
   localparam int PPW  = tsct_pkg::MW + tsct_pkg::QHW;
   localparam int PW   = tsct_pkg::MW + tsct_pkg::QW;

   typedef struct packed {
      tsct_pkg::ctrl_type      ctrl;
      logic signed [TW-1:0]    ts;
      logic signed [TW-1:0]    tc;
      logic signed [SUMW-1:0]  ss;
      logic signed [SUMW-1:0]  sc;
      tsct_pkg::qvec_type      qs;
      tsct_pkg::qvec_type      qc;
   } lvl_type;

   typedef struct packed {
      tsct_pkg::ctrl_type      ctrl;
      logic [PPW-1:0]          pls;
      logic [PPW-1:0]          phs;
      logic [PPW-1:0]          plc;
      logic [PPW-1:0]          phc;
      logic                    negs;
      logic                    negc;
      logic signed [SUMW-1:0]  ss;
      logic signed [SUMW-1:0]  sc;
      tsct_pkg::qvec_type      qs;
      tsct_pkg::qvec_type      qc;
   } mid_type;

   wire lvl_type lvl [0:tsct_pkg::NT];
   lvl_type      lvl0;

   // first terms: x for sine, 1.0 for cosine
   always_comb begin
      lvl0.ctrl = in_head.ctrl;
      lvl0.ts   = {{(TW - tsct_pkg::XW){in_head.x[tsct_pkg::XW-1]}}, in_head.x};
      lvl0.tc   = TW'(1) << tsct_pkg::FRAC;
      lvl0.ss   = {{(SUMW - TW){lvl0.ts[TW-1]}}, lvl0.ts};
      lvl0.sc   = {{(SUMW - TW){lvl0.tc[TW-1]}}, lvl0.tc};
      lvl0.qs   = in_qs;
      lvl0.qc   = in_qc;
   end
   assign lvl[0] = lvl0;

   // each term takes a partial-product stage and an accumulate stage
   for (genvar k = 1; k <= tsct_pkg::NT; k++) begin : g_step
      lvl_type                  prv, lvl_in, lvl_ff;
      mid_type                  mid_in, mid_ff;
      logic [tsct_pkg::MW-1:0]  mags, magc;
      logic [PW-1:0]            fulls, fullc;
      logic [TW-1:0]            ms, mc;

      // magnitude times q, split into two half-width products
      always_comb begin
         prv         = lvl[k-1];
         mags        = tsct_pkg::term_mag(prv.ts);
         magc        = tsct_pkg::term_mag(prv.tc);
         mid_in.ctrl = prv.ctrl;
         mid_in.pls  = PPW'(mags) * PPW'(prv.qs[k-1][tsct_pkg::QHW-1:0]);
         mid_in.phs  = PPW'(mags) * PPW'(prv.qs[k-1][tsct_pkg::QW-1:tsct_pkg::QHW]);
         mid_in.plc  = PPW'(magc) * PPW'(prv.qc[k-1][tsct_pkg::QHW-1:0]);
         mid_in.phc  = PPW'(magc) * PPW'(prv.qc[k-1][tsct_pkg::QW-1:tsct_pkg::QHW]);
         mid_in.negs = ~prv.ts[TW-1];
         mid_in.negc = ~prv.tc[TW-1];
         mid_in.ss   = prv.ss;
         mid_in.sc   = prv.sc;
         mid_in.qs   = prv.qs;
         mid_in.qc   = prv.qc;
      end

      // combine, drop fraction bits, flip sign and accumulate
      always_comb begin
         fulls       = PW'(mid_ff.pls) + (PW'(mid_ff.phs) << tsct_pkg::QHW);
         fullc       = PW'(mid_ff.plc) + (PW'(mid_ff.phc) << tsct_pkg::QHW);
         ms          = fulls[tsct_pkg::FRAC +: TW];
         mc          = fullc[tsct_pkg::FRAC +: TW];
         lvl_in.ctrl = mid_ff.ctrl;
         lvl_in.ts   = mid_ff.negs ? (~ms + 1'b1) : ms;
         lvl_in.tc   = mid_ff.negc ? (~mc + 1'b1) : mc;
         lvl_in.ss   = mid_ff.ss + {{(SUMW - TW){lvl_in.ts[TW-1]}}, lvl_in.ts};
         lvl_in.sc   = mid_ff.sc + {{(SUMW - TW){lvl_in.tc[TW-1]}}, lvl_in.tc};
         lvl_in.qs   = mid_ff.qs;
         lvl_in.qc   = mid_ff.qc;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mid_ff.ctrl.valid <= 1'b0;
            lvl_ff.ctrl.valid <= 1'b0;
         end else if (adv) begin
            mid_ff <= mid_in;
            lvl_ff <= lvl_in;
         end
      end

      assign lvl[k] = lvl_ff;
   end

   assign out_ctrl = lvl[tsct_pkg::NT].ctrl;
   assign out_sin  = lvl[tsct_pkg::NT].ss;
   assign out_cos  = lvl[tsct_pkg::NT].sc;

endmodule

### hdl/tsct_divider.sv
`timescale 1ns / 1ps
module tsct_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  tsct_pkg::ctrl_type               in_ctrl,
   input  logic signed [tsct_pkg::SUMW-1:0] in_sin,
   input  logic signed [tsct_pkg::SUMW-1:0] in_cos,
   output tsct_pkg::div_type                out_st
);

   localparam int MW   = tsct_pkg::MW;
   localparam int NUMW = tsct_pkg::NUMW;

   wire tsct_pkg::div_type st [0:NUMW];
   tsct_pkg::div_type      st0_in, st0_ff;

   // operand magnitudes, quotient sign and pass-through result
   always_comb begin
      st0_in.ctrl = in_ctrl;
      st0_in.rem  = '0;
      st0_in.quo  = '0;
      st0_in.big  = 1'b0;
      st0_in.num  = tsct_pkg::sum_mag(in_sin);
      st0_in.den  = tsct_pkg::sum_mag(in_cos);
      st0_in.neg  = in_sin[tsct_pkg::SUMW-1] ^ in_cos[tsct_pkg::SUMW-1];
      st0_in.zero = (in_cos == '0);
      st0_in.pass = (in_ctrl.op == tsct_pkg::OP_COSINE) ? in_cos : in_sin;
   end

   always_ff @(posedge clock) begin
      if (reset) st0_ff.ctrl.valid <= 1'b0;
      else if (adv) st0_ff <= st0_in;
   end

   assign st[0] = st0_ff;

   // one quotient bit per stage, numerator scaled by 2^28
   for (genvar s = 1; s <= NUMW; s++) begin : g_bit
      localparam int P = NUMW - s;

      tsct_pkg::div_type prv, st_in, st_ff;
      logic              nbit, ge;
      logic [MW:0]       shl, diff;

      if (P >= tsct_pkg::FRAC) begin : g_num
         assign nbit = st[s-1].num[P - tsct_pkg::FRAC];
      end else begin : g_pad
         assign nbit = 1'b0;
      end

      always_comb begin
         prv       = st[s-1];
         shl       = {prv.rem, nbit};
         diff      = shl - {1'b0, prv.den};
         ge        = (shl >= {1'b0, prv.den});
         st_in     = prv;
         st_in.rem = ge ? diff[MW-1:0] : shl[MW-1:0];
         st_in.quo = {prv.quo[tsct_pkg::QOW-2:0], ge};
         st_in.big = prv.big | (ge && (P >= tsct_pkg::QOW));
      end

      always_ff @(posedge clock) begin
         if (reset) st_ff.ctrl.valid <= 1'b0;
         else if (adv) st_ff <= st_in;
      end

      assign st[s] = st_ff;
   end

   assign out_st = st[NUMW];

endmodule

### hdl/taylor_sine_cosine_tangent.sv
// throughput: one transaction per cycle unless a held result stalls, set by the fully pipelined datapath
// (one squaring stage, three quotient stages, two stages per series term,
// one divider stage per quotient bit over a 68-bit scaled numerator)
// reset: synchronous, active high, clears all valid bits; no clearing pass
`timescale 1ns / 1ps
`include "taylor_sine_cosine_tangent_assert.svh"
module taylor_sine_cosine_tangent (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_operation,
   input  logic signed [tsct_pkg::XW-1:0]     req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tsct_pkg::OUTW-1:0]   rsp_value,
   output logic                               rsp_zero_divisor,
   output logic                               rsp_saturated
);

   localparam int OUTW = tsct_pkg::OUTW;
   localparam int SUMW = tsct_pkg::SUMW;

   logic                               adv;
   tsct_pkg::qhead_type                head_in, head_ff, qhead;
   tsct_pkg::qvec_type                 qs, qc;
   tsct_pkg::ctrl_type                 ser_ctrl;
   logic signed [SUMW-1:0]             ser_sin, ser_cos;
   tsct_pkg::div_type                  dv;
   logic [tsct_pkg::XW-1:0]            amag;
   logic [63:0]                        asq;
   logic                               over;
   logic                               rsp_valid_ff;
   logic signed [OUTW-1:0]             value_in, value_ff;
   logic                               zdiv_in, zdiv_ff, sat_in, sat_ff;

   // whole pipeline moves unless a finished result is held
   assign adv       = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~adv;

   // angle magnitude squared in Q.28
   always_comb begin
      amag            = req_angle[tsct_pkg::XW-1] ? (~req_angle + 1'b1) : req_angle;
      asq             = 64'(amag) * 64'(amag);
      head_in.ctrl.valid = req_valid;
      head_in.ctrl.op = tsct_pkg::op_type'(req_operation);
      head_in.x       = req_angle;
      head_in.sq      = asq[tsct_pkg::FRAC +: tsct_pkg::SQW];
   end

   always_ff @(posedge clock) begin
      if (reset) head_ff.ctrl.valid <= 1'b0;
      else if (adv) head_ff <= head_in;
   end

   tsct_quot u_quot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_head  (head_ff),
      .out_head (qhead),
      .out_qs   (qs),
      .out_qc   (qc)
   );

   tsct_series u_series (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_head  (qhead),
      .in_qs    (qs),
      .in_qc    (qc),
      .out_ctrl (ser_ctrl),
      .out_sin  (ser_sin),
      .out_cos  (ser_cos)
   );

   tsct_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctrl (ser_ctrl),
      .in_sin  (ser_sin),
      .in_cos  (ser_cos),
      .out_st  (dv)
   );

   // result select, zero cosine and saturation
   always_comb begin
      value_in = '0;
      zdiv_in  = 1'b0;
      sat_in   = 1'b0;
      over     = 1'b0;
      case (dv.ctrl.op)
         tsct_pkg::OP_SINE, tsct_pkg::OP_COSINE: begin
            value_in = {{(OUTW - SUMW){dv.pass[SUMW-1]}}, dv.pass};
         end
         tsct_pkg::OP_TANGENT: begin
            if (dv.zero) begin
               zdiv_in = 1'b1;
            end else begin
               over = dv.big | (dv.neg ? (dv.quo > tsct_pkg::QUO_MID) : dv.quo[OUTW-1]);
               if (over) begin
                  sat_in   = 1'b1;
                  value_in = dv.neg ? tsct_pkg::OUT_MIN : tsct_pkg::OUT_MAX;
               end else begin
                  value_in = dv.neg ? (~dv.quo + 1'b1) : dv.quo;
               end
            end
         end
         default: begin
            value_in = '0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv.ctrl.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_in;
         zdiv_ff  <= zdiv_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_zero_divisor = zdiv_ff;
   assign rsp_saturated    = sat_ff;

   // checks
   `TSCT_ASSERT_IMP(a_zdiv_clean, clock, reset, rsp_valid && rsp_zero_divisor, rsp_value == '0 && !rsp_saturated)
   `TSCT_ASSERT_IMP(a_sat_limit, clock, reset, rsp_valid && rsp_saturated, rsp_value == tsct_pkg::OUT_MAX || rsp_value == tsct_pkg::OUT_MIN)
   `TSCT_ASSERT_NXT(a_stall_holds, clock, reset, req_stall, rsp_valid)

endmodule
